// ===== hw/rtl/djsq_pkg.sv =====
// Package for the disk job sorted queue: job record, cell flag types and codes.
// Used by djsq_cell and disk_job_sorted_queue_unit; depends on nothing.
package djsq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 64;

   localparam logic [14:0] MAX_JOB_BYTES = 15'd16384;
   localparam logic [20:0] TOTAL_MAX     = 21'h1FFFFF;

   localparam logic       OP_INSERT = 1'b0;
   localparam logic       OP_POP    = 1'b1;

   localparam logic [2:0] ACT_READ  = 3'd0;
   localparam logic [2:0] ACT_WRITE = 3'd1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_DROPPED  = 2'd1;
   localparam logic [1:0] ST_POPPED   = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   localparam logic [1:0] SEL_HOLD  = 2'd0;
   localparam logic [1:0] SEL_LEFT  = 2'd1;
   localparam logic [1:0] SEL_NEW   = 2'd2;
   localparam logic [1:0] SEL_RIGHT = 2'd3;

   typedef struct packed {
      logic [2:0]  prio;
      logic [7:0]  storage;
      logic [19:0] piece;
      logic [23:0] offset;
      logic [2:0]  action;
      logic [14:0] length;
   } job_type;

   typedef struct packed {
      logic stop;
      logic storage_diff;
      logic prio_le;
   } cell_flags_type;

endpackage

// ===== hw/rtl/disk_job_sorted_queue_unit.sv =====
// Disk job sorted queue, top level: a chain of job cells with the placement and pop control.
// Each item goes through the accept, a compare pass over all cells and an apply pass that
// shifts the chain, in that order; a result still waiting on the output stalls the apply pass.
// A new item is accepted only in the idle state, once the last one has left the apply pass.
// Synchronous active-high reset empties the queue and clears the write byte total.
// Depends on djsq_pkg and djsq_cell.
module disk_job_sorted_queue_unit
   import djsq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [2:0]  req_action,
   input  logic [2:0]  req_priority_req,
   input  logic [7:0]  req_storage_id,
   input  logic [19:0] req_piece,
   input  logic [23:0] req_offset,
   input  logic [14:0] req_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_out_action,
   output logic [2:0]  rsp_out_priority,
   output logic [7:0]  rsp_out_storage_id,
   output logic [19:0] rsp_out_piece,
   output logic [23:0] rsp_out_offset,
   output logic [14:0] rsp_out_length,
   output logic [6:0]  rsp_queue_count,
   output logic [20:0] rsp_pending_write_bytes
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CALC  = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic                   op_ff;
   job_type                req_ff;
   logic [CW-1:0]          count_ff, count_in;
   logic [20:0]            total_ff, total_in;
   logic [QUEUE_DEPTH-1:0] stop_ff, diff_ff, ple_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             status_ff, status_in;
   job_type                out_ff, out_in;

   job_type                cell_job [QUEUE_DEPTH];
   cell_flags_type         cell_flags [QUEUE_DEPTH];
   logic [1:0]             cell_sel [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] valid_vec, suffix, pos_vec, tail_vec, new_tail;
   logic [QUEUE_DEPTH-1:0] stop_vec, diff_vec, ple_vec;
   logic                   apply_go, to_tail, mid_diff, head_keep, full;
   logic [31:0]            count_wide;
   logic [21:0]            total_sum;
   job_type                zero_job;

   assign zero_job  = '0;
   assign req_ready = state_ff == S_IDLE;
   assign apply_go  = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_ready);
   assign full      = 32'(count_ff) == QUEUE_DEPTH;

   genvar i;
   generate
      for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         assign valid_vec[i] = 32'(count_ff) > i;
         assign stop_vec[i]  = cell_flags[i].stop;
         assign diff_vec[i]  = cell_flags[i].storage_diff;
         assign ple_vec[i]   = cell_flags[i].prio_le;
         assign suffix[i]    = |stop_ff[QUEUE_DEPTH-1:i];
         if (i == 0) begin : g_first
            assign pos_vec[i]  = !suffix[i];
            assign new_tail[i] = !valid_vec[i];
         end else begin : g_rest
            assign pos_vec[i]  = stop_ff[i-1] && !suffix[i];
            assign new_tail[i] = !valid_vec[i] && valid_vec[i-1];
         end
         if (i == QUEUE_DEPTH - 1) begin : g_last
            assign tail_vec[i] = valid_vec[i];
         end else begin : g_mid
            assign tail_vec[i] = valid_vec[i] && !valid_vec[i+1];
         end

         always_comb begin
            cell_sel[i] = SEL_HOLD;
            if (apply_go) begin
               if (op_ff == OP_POP) begin
                  cell_sel[i] = SEL_RIGHT;
               end else if (!full) begin
                  if (to_tail) begin
                     if (new_tail[i]) begin
                        cell_sel[i] = SEL_NEW;
                     end
                  end else if (pos_vec[i]) begin
                     cell_sel[i] = SEL_NEW;
                  end else if (!suffix[i] && (i > 0) && valid_vec[(i > 0) ? i - 1 : 0]) begin
                     cell_sel[i] = SEL_LEFT;
                  end
               end
            end
         end

         djsq_cell u_cell (
            .clock     (clock),
            .valid     (valid_vec[i]),
            .sel       (cell_sel[i]),
            .req_job   (req_ff),
            .left_job  ((i > 0) ? cell_job[(i > 0) ? i - 1 : 0] : zero_job),
            .right_job ((i < QUEUE_DEPTH - 1) ?
                        cell_job[(i < QUEUE_DEPTH - 1) ? i + 1 : i] : zero_job),
            .job       (cell_job[i]),
            .flags     (cell_flags[i])
         );
      end
   endgenerate

   assign mid_diff  = |(pos_vec & valid_vec & diff_ff);
   assign head_keep = |(tail_vec & ple_ff);
   assign to_tail   = ((req_ff.action != ACT_READ) && (req_ff.action != ACT_WRITE)) ||
                      ((req_ff.action == ACT_WRITE) && suffix[0] && mid_diff) ||
                      (!suffix[0] && (!valid_vec[0] || head_keep));
   assign total_sum = {1'b0, total_ff} + {7'd0, req_ff.length};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      out_in       = out_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (apply_go) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               out_in       = '0;
               if (op_ff == OP_POP) begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     status_in = ST_POPPED;
                     out_in    = cell_job[0];
                     count_in  = count_ff - 1'b1;
                     if (cell_job[0].action == ACT_WRITE) begin
                        total_in = (total_ff >= {6'd0, cell_job[0].length}) ?
                                   total_ff - {6'd0, cell_job[0].length} : '0;
                     end
                  end
               end else if (full) begin
                  status_in = ST_DROPPED;
               end else begin
                  status_in = ST_INSERTED;
                  count_in  = count_ff + 1'b1;
                  if (req_ff.action == ACT_WRITE) begin
                     total_in = total_sum[21] ? TOTAL_MAX : total_sum[20:0];
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      out_ff    <= out_in;
      if (state_ff == S_IDLE && req_valid) begin
         op_ff           <= req_op;
         req_ff.prio     <= req_priority_req;
         req_ff.storage  <= req_storage_id;
         req_ff.piece    <= req_piece;
         req_ff.offset   <= req_offset;
         req_ff.action   <= req_action;
         req_ff.length   <= (req_length > MAX_JOB_BYTES) ? MAX_JOB_BYTES : req_length;
      end
      if (state_ff == S_CALC) begin
         stop_ff <= stop_vec;
         diff_ff <= diff_vec;
         ple_ff  <= ple_vec;
      end
   end

   assign count_wide              = 32'(count_ff);
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = status_ff;
   assign rsp_out_action          = out_ff.action;
   assign rsp_out_priority        = out_ff.prio;
   assign rsp_out_storage_id      = out_ff.storage;
   assign rsp_out_piece           = out_ff.piece;
   assign rsp_out_offset          = out_ff.offset;
   assign rsp_out_length          = out_ff.length;
   assign rsp_queue_count         = count_wide[6:0];
   assign rsp_pending_write_bytes = total_ff;

endmodule

// ===== hw/rtl/djsq_cell.sv =====
// One queue slot: holds a job, compares it with the incoming job and moves data
// to or from its neighbours. Depends on djsq_pkg.
module djsq_cell
   import djsq_pkg::*;
(
   input  logic           clock,
   input  logic           valid,
   input  logic [1:0]     sel,
   input  job_type        req_job,
   input  job_type        left_job,
   input  job_type        right_job,
   output job_type        job,
   output cell_flags_type flags
);

   job_type     job_ff;
   job_type     job_in;
   logic        ahead;
   logic        overlap;
   logic [24:0] end_cell;
   logic [24:0] end_req;

   always_comb begin
      case (sel)
         SEL_LEFT:  job_in = left_job;
         SEL_NEW:   job_in = req_job;
         SEL_RIGHT: job_in = right_job;
         default:   job_in = job_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign end_cell = {1'b0, job_ff.offset} + {10'd0, job_ff.length};
   assign end_req  = {1'b0, req_job.offset} + {10'd0, req_job.length};

   always_comb begin
      ahead = (job_ff.prio > req_job.prio) ||
              ((job_ff.prio == req_job.prio) &&
               ({job_ff.storage, job_ff.piece, job_ff.offset} <
                {req_job.storage, req_job.piece, req_job.offset}));
      overlap = ((job_ff.offset <= req_job.offset) && (end_cell > {1'b0, req_job.offset})) ||
                ((req_job.offset <= job_ff.offset) && (end_req > {1'b0, job_ff.offset}));
      flags.stop = valid && (ahead ||
                   ((req_job.action == ACT_READ) && (job_ff.action == ACT_WRITE) &&
                    (job_ff.storage == req_job.storage) && (job_ff.piece == req_job.piece) &&
                    overlap));
      flags.storage_diff = job_ff.storage != req_job.storage;
      flags.prio_le      = req_job.prio <= job_ff.prio;
   end

   assign job = job_ff;

endmodule

// ===== sim/disk_job_sorted_queue_unit_test.sv =====
// Self-checking testbench for disk_job_sorted_queue_unit: directed and random insert/pop items,
// results compared against a behavioural copy of the sorted job queue held here.
// Depends on djsq_pkg and the RTL of the queue unit.
module disk_job_sorted_queue_unit_test
   import djsq_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = DEFAULT_QUEUE_DEPTH;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic        op;
      logic [2:0]  action;
      logic [2:0]  prio;
      logic [7:0]  storage;
      logic [19:0] piece;
      logic [23:0] offset;
      logic [14:0] length;
   } job_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  action;
      logic [2:0]  prio;
      logic [7:0]  storage;
      logic [19:0] piece;
      logic [23:0] offset;
      logic [14:0] length;
      logic [6:0]  count;
      logic [20:0] wbytes;
   } job_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_op = 1'b0;
   logic [2:0] req_action = '0;
   logic [2:0] req_priority_req = '0;
   logic [7:0] req_storage_id = '0;
   logic [19:0] req_piece = '0;
   logic [23:0] req_offset = '0;
   logic [14:0] req_length = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [2:0] rsp_out_action;
   logic [2:0] rsp_out_priority;
   logic [7:0] rsp_out_storage_id;
   logic [19:0] rsp_out_piece;
   logic [23:0] rsp_out_offset;
   logic [14:0] rsp_out_length;
   logic [6:0] rsp_queue_count;
   logic [20:0] rsp_pending_write_bytes;

   disk_job_sorted_queue_unit i_dut (.*);

   always #1 clock = ~clock;

   job_item_type pending_items[$];
   job_result_type expected_results[$];
   job_type model_jobs[$];
   logic [20:0] model_write_bytes = '0;
   int error_count = 0;
   int idle_percent = 38;
   bit hold_sender = 1'b0;
   int quiet_cycles = 0;

   function automatic void add_item(job_item_type it);
      pending_items.insert(pending_items.size(), it);
   endfunction

   function automatic logic [51:0] low_key(job_type j);
      return {j.storage, j.piece, j.offset};
   endfunction

   function automatic bit goes_before(job_type a, job_type b);
      if (a.prio != b.prio) return a.prio > b.prio;
      return low_key(a) < low_key(b);
   endfunction

   function automatic bit spans_overlap(logic [23:0] s1, logic [14:0] l1,
                                        logic [23:0] s2, logic [14:0] l2);
      longint a, b;
      a = s1;
      b = s2;
      return (a <= b && a + l1 > b) || (b <= a && b + l2 > a);
   endfunction

   function automatic job_result_type predict_queue(job_item_type it);
      job_result_type r;
      job_type nj, hj;
      int n, idx, pos;
      logic [21:0] sum;
      r = '0;
      n = model_jobs.size();
      if (it.op == OP_POP) begin
         if (n == 0) begin
            r.status = ST_EMPTY;
         end else begin
            hj = model_jobs[0];
            model_jobs.delete(0);
            if (hj.action == ACT_WRITE)
               model_write_bytes = (model_write_bytes >= hj.length) ?
                                   model_write_bytes - hj.length : '0;
            r.status = ST_POPPED;
            r.action = hj.action;
            r.prio = hj.prio;
            r.storage = hj.storage;
            r.piece = hj.piece;
            r.offset = hj.offset;
            r.length = hj.length;
         end
      end else if (n >= DEPTH) begin
         r.status = ST_DROPPED;
      end else begin
         nj.prio = it.prio;
         nj.storage = it.storage;
         nj.piece = it.piece;
         nj.offset = it.offset;
         nj.action = it.action;
         nj.length = (it.length > MAX_JOB_BYTES) ? MAX_JOB_BYTES : it.length;
         if (it.action == ACT_READ) begin
            for (idx = n - 1; idx >= 0; idx--) begin
               if (goes_before(model_jobs[idx], nj)) break;
               if (model_jobs[idx].action == ACT_WRITE && model_jobs[idx].storage == nj.storage
                   && model_jobs[idx].piece == nj.piece
                   && spans_overlap(model_jobs[idx].offset, model_jobs[idx].length,
                                    nj.offset, nj.length)) break;
            end
            pos = idx + 1;
         end else if (it.action == ACT_WRITE) begin
            for (idx = n - 1; idx >= 0; idx--) begin
               if (goes_before(model_jobs[idx], nj)) begin
                  if (idx != n - 1 && model_jobs[idx + 1].storage != nj.storage) idx = n - 1;
                  break;
               end
            end
            pos = idx + 1;
         end else begin
            pos = n;
         end
         if (pos == 0 && (n == 0 || nj.prio <= model_jobs[n - 1].prio)) pos = n;
         model_jobs.insert(pos, nj);
         if (it.action == ACT_WRITE) begin
            sum = model_write_bytes + nj.length;
            model_write_bytes = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[20:0];
         end
         r.status = ST_INSERTED;
      end
      r.count = 7'(model_jobs.size());
      r.wbytes = model_write_bytes;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_items.size() > 0 && !hold_sender && $urandom_range(99) >= idle_percent) begin
            job_item_type it;
            it = pending_items[0];
            pending_items.delete(0);
            req_valid <= 1'b1;
            req_op <= it.op;
            req_action <= it.action;
            req_priority_req <= it.prio;
            req_storage_id <= it.storage;
            req_piece <= it.piece;
            req_offset <= it.offset;
            req_length <= it.length;
            expected_results.insert(expected_results.size(), predict_queue(it));
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_status, -1);
            end else begin
               job_result_type e;
               e = expected_results[0];
               expected_results.delete(0);
               if (rsp_status != e.status) report_mismatch("status", rsp_status, e.status);
               if (rsp_out_action != e.action)
                  report_mismatch("out_action", rsp_out_action, e.action);
               if (rsp_out_priority != e.prio)
                  report_mismatch("out_priority", rsp_out_priority, e.prio);
               if (rsp_out_storage_id != e.storage)
                  report_mismatch("out_storage_id", rsp_out_storage_id, e.storage);
               if (rsp_out_piece != e.piece) report_mismatch("out_piece", rsp_out_piece, e.piece);
               if (rsp_out_offset != e.offset)
                  report_mismatch("out_offset", rsp_out_offset, e.offset);
               if (rsp_out_length != e.length)
                  report_mismatch("out_length", rsp_out_length, e.length);
               if (rsp_queue_count != e.count)
                  report_mismatch("queue_count", rsp_queue_count, e.count);
               if (rsp_pending_write_bytes != e.wbytes)
                  report_mismatch("pending_write_bytes", rsp_pending_write_bytes, e.wbytes);
            end
         end
         rsp_ready <= ($urandom_range(99) >= idle_percent);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   function automatic job_item_type make_job(logic op, logic [2:0] act, logic [2:0] prio,
                                             logic [7:0] stor, logic [19:0] pc,
                                             logic [23:0] offs, logic [14:0] len);
      job_item_type it;
      it.op = op;
      it.action = act;
      it.prio = prio;
      it.storage = stor;
      it.piece = pc;
      it.offset = offs;
      it.length = len;
      return it;
   endfunction

   function automatic job_item_type random_job(int burst);
      job_item_type it;
      it.op = ($urandom_range(99) < 40) ? OP_POP : OP_INSERT;
      it.action = ($urandom_range(9) < 8) ? 3'($urandom_range(1)) : 3'($urandom_range(7));
      it.prio = 3'($urandom_range(7));
      if ($urandom_range(3) == 0) begin
         it.storage = 8'($urandom);
         it.piece = 20'($urandom);
         it.offset = 24'($urandom);
      end else begin
         it.storage = 8'($urandom_range(3)) + 8'(burst) * 8'd4;
         it.piece = 20'($urandom_range(2));
         it.offset = 24'($urandom_range(4)) * 24'd4096;
      end
      it.length = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(16384));
      return it;
   endfunction

   task automatic wait_drained();
      while (pending_items.size() > 0 || expected_results.size() > 0 || req_valid)
         @(posedge clock);
   endtask

   initial begin
      int b;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      add_item(make_job(OP_POP, 3'd0, 3'd0, 8'd0, 20'd0, 24'd0, 15'd0));
      add_item(make_job(OP_INSERT, ACT_WRITE, 3'd3, 8'd5, 20'd1, 24'd0, 15'd4096));
      add_item(make_job(OP_INSERT, ACT_READ, 3'd3, 8'd5, 20'd1, 24'd100, 15'd10));
      add_item(make_job(OP_INSERT, ACT_WRITE, 3'd3, 8'd2, 20'd0, 24'd0, 15'd32767));
      add_item(make_job(OP_INSERT, ACT_READ, 3'd7, 8'd255, 20'hFFFFF, 24'hFFFFFF, 15'h7FFF));
      add_item(make_job(OP_INSERT, ACT_READ, 3'd0, 8'd0, 20'd0, 24'd0, 15'd0));
      for (int a = 2; a < 8; a++)
         add_item(make_job(OP_INSERT, 3'(a), 3'(a), 8'(a), 20'(a), 24'(a), 15'd16384));
      add_item(make_job(OP_INSERT, ACT_WRITE, 3'd3, 8'd5, 20'd1, 24'd0, 15'd4096));
      add_item(make_job(OP_INSERT, ACT_READ, 3'd6, 8'd1, 20'd0, 24'd0, 15'd1));
      for (int p = 0; p < 16; p++)
         add_item(make_job(OP_POP, 3'd0, 3'd0, 8'd0, 20'd0, 24'd0, 15'd0));
      wait_drained();
      // Fill past capacity with large writes to reach the full case.
      for (int f = 0; f < DEPTH + 4; f++)
         add_item(make_job(OP_INSERT, ACT_WRITE, 3'($urandom_range(7)),
                           8'($urandom), 20'($urandom), 24'($urandom), 15'd16384));
      for (int p = 0; p < DEPTH + 2; p++)
         add_item(make_job(OP_POP, 3'd0, 3'd0, 8'd0, 20'd0, 24'd0, 15'd0));
      wait_drained();
      hold_sender = 1'b1;
      repeat (20) @(posedge clock);
      hold_sender = 1'b0;
      idle_percent = 0;
      for (int i = 0; i < 200; i++) add_item(random_job(i / 20));
      wait_drained();
      idle_percent = 38;
      for (b = 0; b < 940; b++) add_item(random_job(b / 25));
      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
hw/rtl/djsq_pkg.sv
hw/rtl/djsq_cell.sv
hw/rtl/disk_job_sorted_queue_unit.sv
sim/disk_job_sorted_queue_unit_test.sv
